### src/line_segment_rect_clip_assert.svh
// Assertion macros used by the clipper top level
`ifndef LINE_SEGMENT_RECT_CLIP_ASSERT_SVH
`define LINE_SEGMENT_RECT_CLIP_ASSERT_SVH

// checked only out of reset
`define LSRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define LSRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/lsrc_pkg.sv
// Shared constants and types of the segment clipper
package lsrc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int NUM_EDGES      = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_MIN = 2'd0,
        CFG_Y_MIN = 2'd1,
        CFG_X_MAX = 2'd2,
        CFG_Y_MAX = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_TOP    = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_BOTTOM = 2'd3
    } edge_t;

    localparam int RESET_X_MIN = 0;
    localparam int RESET_Y_MIN = 0;
    localparam int RESET_X_MAX = 1023;
    localparam int RESET_Y_MAX = 767;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

### src/line_segment_rect_clip.sv
// Top level of the Cyrus-Beck segment clipper
//
//  channel | direction | handshake              | word
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  s       | in        | s_valid / s_ready      | start and end point
//  m       | out       | m_valid / m_ready      | accepted flag, clipped points
//
// One segment per cycle sustained while m is not stalled; m_valid rises once the
// word has passed front register, queue, divider, merge, product and output regs.
// Latency is set by the per-edge restoring divider, one quotient bit per stage.
// Synchronous active-low reset empties front register, queue and pipeline.
// A stall on m freezes the pipeline; the two-word queue and front register
// keep s_ready high meanwhile until they fill.
// cfg_ready is always high; writes take effect on the next segment.
module line_segment_rect_clip #(
    parameter int COORD_BITS      = 16,
    parameter int T_FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_start_x,
    input  logic signed [COORD_BITS-1:0]        s_start_y,
    input  logic signed [COORD_BITS-1:0]        s_end_x,
    input  logic signed [COORD_BITS-1:0]        s_end_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic signed [COORD_BITS-1:0]        m_clipped_start_x,
    output logic signed [COORD_BITS-1:0]        m_clipped_start_y,
    output logic signed [COORD_BITS-1:0]        m_clipped_end_x,
    output logic signed [COORD_BITS-1:0]        m_clipped_end_y
);
    import lsrc_pkg::*;

    `include "line_segment_rect_clip_assert.svh"

    localparam int WW = 2*COORD_BITS + 6*(COORD_BITS+1);

    hs_t           front_hs;
    logic          front_ready;
    logic [WW-1:0] front_data;
    logic          q_valid, q_ready;
    logic [WW-1:0] q_data;

    lsrc_front #(.C(COORD_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .word_hs_o  (front_hs),
        .word_ready (front_ready),
        .word_data  (front_data)
    );

    lsrc_fifo #(.WIDTH(WW), .DEPTH(2)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_hs.valid),
        .wr_ready (front_ready),
        .wr_data  (front_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    lsrc_back #(.C(COORD_BITS), .F(T_FRACTION_BITS)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (q_valid),
        .in_ready          (q_ready),
        .in_data           (q_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_clipped_start_x (m_clipped_start_x),
        .m_clipped_start_y (m_clipped_start_y),
        .m_clipped_end_x   (m_clipped_end_x),
        .m_clipped_end_y   (m_clipped_end_y)
    );

    `LSRC_ASSERT(a_reject_zero,
        m_valid && !m_accepted |-> (m_clipped_start_x == '0) && (m_clipped_start_y == '0)
            && (m_clipped_end_x == '0) && (m_clipped_end_y == '0),
        "rejected word carries nonzero coordinates")
    `LSRC_ASSERT_ALWAYS(a_reset_m_idle, !aresetn |=> !m_valid, "result valid right after reset")
    `LSRC_ASSERT_ALWAYS(a_reset_s_ready, !aresetn |=> s_ready, "input not ready right after reset")
    `LSRC_ASSERT(a_queue_flow, front_hs.valid && !front_ready |=> front_hs.valid,
        "front word lost while queue full")

endmodule

### src/lsrc_front.sv
// Front end: window registers, edge distances and segment deltas
module lsrc_front #(
    parameter int C = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [C-1:0]                        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [C-1:0]                 s_start_x,
    input  logic signed [C-1:0]                 s_start_y,
    input  logic signed [C-1:0]                 s_end_x,
    input  logic signed [C-1:0]                 s_end_y,
    output lsrc_pkg::hs_t                       word_hs_o,
    input  logic                                word_ready,
    output logic [2*C+6*(C+1)-1:0]              word_data
);
    import lsrc_pkg::*;

    localparam int WW = 2*C + 6*(C+1);

    logic signed [C-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic                valid_reg;
    logic [WW-1:0]       word_reg;
    logic [WW-1:0]       word_next;
    logic signed [C:0]   dx, dy, q_left, q_top, q_right, q_bottom;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= C'(RESET_X_MIN);
            y_min_reg <= C'(RESET_Y_MIN);
            x_max_reg <= C'(RESET_X_MAX);
            y_max_reg <= C'(RESET_Y_MAX);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_X_MIN: x_min_reg <= cfg_data;
                CFG_Y_MIN: y_min_reg <= cfg_data;
                CFG_X_MAX: x_max_reg <= cfg_data;
                CFG_Y_MAX: y_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx       = (C+1)'(s_end_x)   - (C+1)'(s_start_x);
        dy       = (C+1)'(s_end_y)   - (C+1)'(s_start_y);
        q_left   = (C+1)'(s_start_x) - (C+1)'(x_min_reg);
        q_top    = (C+1)'(y_max_reg) - (C+1)'(s_start_y);
        q_right  = (C+1)'(x_max_reg) - (C+1)'(s_start_x);
        q_bottom = (C+1)'(s_start_y) - (C+1)'(y_min_reg);
        word_next = {s_start_x, s_start_y, dx, dy, q_left, q_top, q_right, q_bottom};
    end

    assign s_ready = !valid_reg || word_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= word_next;
        end
    end

    assign word_hs_o.valid = valid_reg;
    assign word_hs_o.ready = word_ready;
    assign word_data       = word_reg;

endmodule

### src/lsrc_fifo.sv
// Short queue between the front end and the clipping pipeline
module lsrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/lsrc_back.sv
// Clipping pipeline: per-edge divide, tmin/tmax merge, interpolation, output word
module lsrc_back #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2*C+6*(C+1)-1:0]     in_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic signed [C-1:0]        m_clipped_start_x,
    output logic signed [C-1:0]        m_clipped_start_y,
    output logic signed [C-1:0]        m_clipped_end_x,
    output logic signed [C-1:0]        m_clipped_end_y
);
    import lsrc_pkg::*;

    localparam int QW = F + 2;
    localparam int TW = QW + 1;
    localparam int L  = QW;
    localparam int PW = C + 1 + F + 2;
    localparam logic [QW-1:0] T_CLAMP = QW'((1 << F) + 1);
    localparam logic signed [TW-1:0] T_ONE = TW'(1 << F);
    localparam logic signed [PW-1:0] T_HALF = PW'(1 << (F - 1));

    logic adv;

    // divider pipeline stages 0..L
    logic              vld_reg  [L+1];
    logic [C:0]        rem_reg  [L+1][NUM_EDGES];
    logic [QW-1:0]     nlo_reg  [L+1][NUM_EDGES];
    logic [QW-1:0]     quo_reg  [L+1][NUM_EDGES];
    logic [C:0]        den_reg  [L+1][NUM_EDGES];
    logic              neg_reg  [L+1][NUM_EDGES];
    logic              ppos_reg [L+1][NUM_EDGES];
    logic              pz_reg   [L+1][NUM_EDGES];
    logic              sat_reg  [L+1][NUM_EDGES];
    logic              rej_reg  [L+1];
    logic signed [C-1:0] x1_reg [L+1];
    logic signed [C-1:0] y1_reg [L+1];
    logic signed [C:0]   dx_reg [L+1];
    logic signed [C:0]   dy_reg [L+1];

    logic [C:0]        rem_next [1:L][NUM_EDGES];
    logic [QW-1:0]     nlo_next [1:L][NUM_EDGES];
    logic [QW-1:0]     quo_next [1:L][NUM_EDGES];
    logic [C:0]        rem0_next[NUM_EDGES];
    logic [QW-1:0]     nlo0_next[NUM_EDGES];
    logic [QW-1:0]     quo0_next[NUM_EDGES];
    logic [C:0]        den_next [NUM_EDGES];
    logic              neg_next [NUM_EDGES];
    logic              ppos_next[NUM_EDGES];
    logic              pz_next  [NUM_EDGES];
    logic              sat_next [NUM_EDGES];
    logic              rej_next;

    logic signed [C-1:0] in_x1, in_y1;
    logic signed [C:0]   in_dx, in_dy;
    logic signed [C:0]   in_q [NUM_EDGES];
    logic signed [C:0]   in_p [NUM_EDGES];

    assign adv      = !m_valid || m_ready;
    assign in_ready = adv;

    assign {in_x1, in_y1, in_dx, in_dy,
            in_q[EDGE_LEFT], in_q[EDGE_TOP], in_q[EDGE_RIGHT], in_q[EDGE_BOTTOM]} = in_data;

    always_comb begin
        logic [C:0]      aq, ap;
        logic [C+QW-1:0] num;
        in_p[EDGE_LEFT]   = in_dx;
        in_p[EDGE_TOP]    = -in_dy;
        in_p[EDGE_RIGHT]  = -in_dx;
        in_p[EDGE_BOTTOM] = in_dy;
        rej_next = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            aq = in_q[e][C] ? -in_q[e] : in_q[e];
            ap = in_p[e][C] ? -in_p[e] : in_p[e];
            pz_next[e]   = (in_p[e] == '0);
            ppos_next[e] = !in_p[e][C] && !pz_next[e];
            neg_next[e]  = (in_q[e][C] == in_p[e][C]) && (in_q[e] != '0);
            rej_next     = rej_next | (pz_next[e] && in_q[e][C]);
            num          = ((C+QW)'(aq[C-1:0]) << (F + 1)) + (C+QW)'(ap[C-1:0]);
            den_next[e]  = {ap[C-1:0], 1'b0};
            sat_next[e]  = ({1'b0, num[C+QW-1:QW]} >= den_next[e]);
            rem0_next[e] = {1'b0, num[C+QW-1:QW]};
            nlo0_next[e] = num[QW-1:0];
            quo0_next[e] = '0;
        end
    end

    // one quotient bit per stage
    always_comb begin
        logic [C+1:0] sh;
        for (int s = 1; s <= L; s++) begin
            for (int e = 0; e < NUM_EDGES; e++) begin
                sh = {rem_reg[s-1][e], nlo_reg[s-1][e][QW-1]};
                nlo_next[s][e] = {nlo_reg[s-1][e][QW-2:0], 1'b0};
                if (sh >= {1'b0, den_reg[s-1][e]}) begin
                    rem_next[s][e] = (C+1)'(sh - {1'b0, den_reg[s-1][e]});
                    quo_next[s][e] = {quo_reg[s-1][e][QW-2:0], 1'b1};
                end else begin
                    rem_next[s][e] = sh[C:0];
                    quo_next[s][e] = {quo_reg[s-1][e][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= L; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= L; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rej_reg[0] <= rej_next;
            x1_reg[0]  <= in_x1;
            y1_reg[0]  <= in_y1;
            dx_reg[0]  <= in_dx;
            dy_reg[0]  <= in_dy;
            for (int e = 0; e < NUM_EDGES; e++) begin
                rem_reg[0][e]  <= rem0_next[e];
                nlo_reg[0][e]  <= nlo0_next[e];
                quo_reg[0][e]  <= quo0_next[e];
                den_reg[0][e]  <= den_next[e];
                neg_reg[0][e]  <= neg_next[e];
                ppos_reg[0][e] <= ppos_next[e];
                pz_reg[0][e]   <= pz_next[e];
                sat_reg[0][e]  <= sat_next[e];
            end
            for (int s = 1; s <= L; s++) begin
                rej_reg[s] <= rej_reg[s-1];
                x1_reg[s]  <= x1_reg[s-1];
                y1_reg[s]  <= y1_reg[s-1];
                dx_reg[s]  <= dx_reg[s-1];
                dy_reg[s]  <= dy_reg[s-1];
                for (int e = 0; e < NUM_EDGES; e++) begin
                    rem_reg[s][e]  <= rem_next[s][e];
                    nlo_reg[s][e]  <= nlo_next[s][e];
                    quo_reg[s][e]  <= quo_next[s][e];
                    den_reg[s][e]  <= den_reg[s-1][e];
                    neg_reg[s][e]  <= neg_reg[s-1][e];
                    ppos_reg[s][e] <= ppos_reg[s-1][e];
                    pz_reg[s][e]   <= pz_reg[s-1][e];
                    sat_reg[s][e]  <= sat_reg[s-1][e];
                end
            end
        end
    end

    // merge the left, top, right and bottom edge parameters into tmin and tmax
    logic signed [TW-1:0] tmin_next, tmax_next;
    logic                 ok_next;

    always_comb begin
        logic [QW-1:0]        mag;
        logic signed [TW-1:0] t;
        tmin_next = '0;
        tmax_next = T_ONE;
        for (int e = 0; e < NUM_EDGES; e++) begin
            mag = (sat_reg[L][e] || quo_reg[L][e] > T_CLAMP) ? T_CLAMP : quo_reg[L][e];
            t   = neg_reg[L][e] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (!pz_reg[L][e]) begin
                if (ppos_reg[L][e]) begin
                    if (t > tmin_next) tmin_next = t;
                end else begin
                    if (t < tmax_next) tmax_next = t;
                end
            end
        end
        ok_next = !rej_reg[L] && (tmin_next <= tmax_next);
    end

    logic                mg_vld_reg, mg_ok_reg;
    logic [F:0]          mg_tmin_reg, mg_tmax_reg;
    logic signed [C-1:0] mg_x1_reg, mg_y1_reg;
    logic signed [C:0]   mg_dx_reg, mg_dy_reg;

    logic                ml_vld_reg, ml_ok_reg;
    logic signed [C-1:0] ml_x1_reg, ml_y1_reg;
    logic signed [PW-1:0] ml_p0_reg, ml_p1_reg, ml_p2_reg, ml_p3_reg;

    logic                out_vld_reg, out_ok_reg;
    logic signed [C-1:0] out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    function automatic logic signed [C-1:0] lerp_fin(input logic signed [C-1:0] a,
                                                     input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] sum;
        sum = (prod + T_HALF) >>> F;
        return a + sum[C-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mg_vld_reg  <= 1'b0;
            ml_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            mg_vld_reg  <= vld_reg[L];
            ml_vld_reg  <= mg_vld_reg;
            out_vld_reg <= ml_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mg_ok_reg   <= ok_next;
            mg_tmin_reg <= tmin_next[F:0];
            mg_tmax_reg <= tmax_next[F:0];
            mg_x1_reg   <= x1_reg[L];
            mg_y1_reg   <= y1_reg[L];
            mg_dx_reg   <= dx_reg[L];
            mg_dy_reg   <= dy_reg[L];

            ml_ok_reg <= mg_ok_reg;
            ml_x1_reg <= mg_x1_reg;
            ml_y1_reg <= mg_y1_reg;
            ml_p0_reg <= PW'(mg_dx_reg) * PW'($signed({1'b0, mg_tmin_reg}));
            ml_p1_reg <= PW'(mg_dy_reg) * PW'($signed({1'b0, mg_tmin_reg}));
            ml_p2_reg <= PW'(mg_dx_reg) * PW'($signed({1'b0, mg_tmax_reg}));
            ml_p3_reg <= PW'(mg_dy_reg) * PW'($signed({1'b0, mg_tmax_reg}));

            out_ok_reg <= ml_ok_reg;
            out_sx_reg <= ml_ok_reg ? lerp_fin(ml_x1_reg, ml_p0_reg) : '0;
            out_sy_reg <= ml_ok_reg ? lerp_fin(ml_y1_reg, ml_p1_reg) : '0;
            out_ex_reg <= ml_ok_reg ? lerp_fin(ml_x1_reg, ml_p2_reg) : '0;
            out_ey_reg <= ml_ok_reg ? lerp_fin(ml_y1_reg, ml_p3_reg) : '0;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_accepted        = out_ok_reg;
    assign m_clipped_start_x = out_sx_reg;
    assign m_clipped_start_y = out_sy_reg;
    assign m_clipped_end_x   = out_ex_reg;
    assign m_clipped_end_y   = out_ey_reg;

endmodule
